/* sv/gpfs_pkg.sv */
`timescale 1ns / 1ps

package gpfs_pkg;

   localparam logic [1:0] OP_POLL = 2'd0;
   localparam logic [1:0] OP_CONFIGURE = 2'd1;
   localparam logic [1:0] OP_RESPONSE = 2'd2;

   localparam logic [1:0] KIND_POLL = 2'd0;
   localparam logic [1:0] KIND_CONFIGURE = 2'd1;
   localparam logic [1:0] KIND_RESPONSE = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam logic [1:0] STEP_POLL = 2'd0;
   localparam logic [1:0] STEP_ENTER = 2'd1;
   localparam logic [1:0] STEP_MODE = 2'd2;
   localparam logic [1:0] STEP_EXIT = 2'd3;

   localparam logic [7:0] CMD_START = 8'h01;
   localparam logic [7:0] CMD_READ_DATA = 8'h42;
   localparam logic [7:0] CMD_CONFIG = 8'h43;
   localparam logic [7:0] CMD_MODE = 8'h44;
   localparam logic [7:0] CMD_FILL = 8'h5A;
   localparam logic [7:0] CMD_LOCK = 8'h03;
   localparam logic [7:0] CMD_UNLOCK = 8'h02;
   localparam logic [7:0] CMD_ZERO = 8'h00;

   localparam int unsigned STORED_BYTES = 6;
   localparam int unsigned FIRST_STORED = 3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       select_active;
      logic       frame_done;
      logic       sequence_done;
      logic [7:0] button_byte_a;
      logic [7:0] button_byte_b;
      logic [7:0] right_x;
      logic [7:0] right_y;
      logic [7:0] left_x;
      logic [7:0] left_y;
      logic       digital_mode;
   } result_type;

   function automatic logic [7:0] command_byte(input logic [1:0] step, input logic [7:0] idx,
                                               input logic digital, input logic lock);
      logic [7:0] cmd;
      cmd = CMD_ZERO;
      case (step)
         STEP_POLL: begin
            if (idx == 8'd0) cmd = CMD_START;
            else if (idx == 8'd1) cmd = CMD_READ_DATA;
         end
         STEP_ENTER: begin
            if (idx == 8'd0) cmd = CMD_START;
            else if (idx == 8'd1) cmd = CMD_CONFIG;
            else if (idx == 8'd3) cmd = CMD_START;
         end
         STEP_MODE: begin
            if (idx == 8'd0) cmd = CMD_START;
            else if (idx == 8'd1) cmd = CMD_MODE;
            else if (idx == 8'd3) cmd = digital ? CMD_ZERO : CMD_START;
            else if (idx == 8'd4) cmd = lock ? CMD_LOCK : CMD_UNLOCK;
         end
         default: begin
            if (idx == 8'd0) cmd = CMD_START;
            else if (idx == 8'd1) cmd = CMD_CONFIG;
            else if (idx >= 8'd4 && idx <= 8'd8) cmd = CMD_FILL;
         end
      endcase
      return cmd;
   endfunction

endpackage

/* sv/gpfs_fifo.sv */
`timescale 1ns / 1ps

module gpfs_fifo #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign dout = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         if (do_push && !do_pop) count_ff <= count_ff + 2'd1;
         else if (do_pop && !do_push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

/* sv/gpfs_front.sv */
`timescale 1ns / 1ps

module gpfs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [1:0]          operation,
   input  logic [7:0]          rx_byte,
   output logic                item_valid,
   output gpfs_pkg::item_type  item,
   input  logic                item_take
);

   gpfs_pkg::item_type classified;
   logic               queue_empty;
   logic [$bits(gpfs_pkg::item_type)-1:0] queue_dout;

   always_comb begin
      classified.rx_byte = rx_byte;
      case (operation)
         gpfs_pkg::OP_POLL:      classified.kind = gpfs_pkg::KIND_POLL;
         gpfs_pkg::OP_CONFIGURE: classified.kind = gpfs_pkg::KIND_CONFIGURE;
         gpfs_pkg::OP_RESPONSE:  classified.kind = gpfs_pkg::KIND_RESPONSE;
         default:                classified.kind = gpfs_pkg::KIND_NONE;
      endcase
   end

   gpfs_fifo #(
      .WIDTH($bits(gpfs_pkg::item_type))
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .din  (classified),
      .full (full),
      .pop  (item_take),
      .dout (queue_dout),
      .empty(queue_empty)
   );

   assign item_valid = !queue_empty;
   assign item = gpfs_pkg::item_type'(queue_dout);

endmodule

/* sv/gpfs_back.sv */
`timescale 1ns / 1ps

module gpfs_back #(
   parameter int unsigned FRAME_BYTES = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  gpfs_pkg::item_type   item,
   output logic                 item_take,
   input  logic                 analog_mode,
   input  logic                 lock_controller,
   input  logic                 result_full,
   output logic                 result_push,
   output gpfs_pkg::result_type result
);

   localparam int unsigned IDX_W = $clog2(FRAME_BYTES);

   logic             busy_ff, busy_in;
   logic [1:0]       step_ff, step_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       pad_ff [gpfs_pkg::STORED_BYTES];
   logic [7:0]       pad_in [gpfs_pkg::STORED_BYTES];
   logic             digital_ff, digital_in;
   logic [IDX_W:0]   idx_next;
   logic [7:0]       tx;
   logic             sel;
   logic             fdone;
   logic             sdone;

   assign item_take = item_valid && !result_full;
   assign result_push = item_take;
   assign idx_next = {1'b0, idx_ff} + (IDX_W + 1)'(1);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      idx_in = idx_ff;
      pad_in = pad_ff;
      digital_in = digital_ff;
      tx = gpfs_pkg::CMD_ZERO;
      sel = 1'b0;
      fdone = 1'b0;
      sdone = 1'b0;
      if (busy_ff) begin
         sel = 1'b1;
         if (item.kind == gpfs_pkg::KIND_RESPONSE) begin
            for (int k = 0; k < gpfs_pkg::STORED_BYTES; k++) begin
               if (idx_ff == IDX_W'(k + gpfs_pkg::FIRST_STORED)) begin
                  if (step_ff == gpfs_pkg::STEP_POLL && k < 2) begin
                     pad_in[k] = item.rx_byte ^ pad_ff[k];
                  end else begin
                     pad_in[k] = item.rx_byte;
                  end
               end
            end
            if (idx_next == (IDX_W + 1)'(FRAME_BYTES)) begin
               fdone = 1'b1;
               sel = 1'b0;
               idx_in = '0;
               if (step_ff == gpfs_pkg::STEP_POLL || step_ff == gpfs_pkg::STEP_EXIT) begin
                  sdone = 1'b1;
                  busy_in = 1'b0;
                  step_in = gpfs_pkg::STEP_POLL;
               end else begin
                  step_in = step_ff + 2'd1;
                  tx = gpfs_pkg::command_byte(step_in, 8'd0, digital_ff, lock_controller);
               end
            end else begin
               idx_in = idx_next[IDX_W-1:0];
               tx = gpfs_pkg::command_byte(step_ff, 8'(idx_next), digital_ff, lock_controller);
            end
         end else begin
            tx = gpfs_pkg::command_byte(step_ff, 8'(idx_ff), digital_ff, lock_controller);
         end
      end else if (item.kind == gpfs_pkg::KIND_POLL || item.kind == gpfs_pkg::KIND_CONFIGURE) begin
         busy_in = 1'b1;
         idx_in = '0;
         sel = 1'b1;
         if (item.kind == gpfs_pkg::KIND_POLL) begin
            step_in = gpfs_pkg::STEP_POLL;
         end else begin
            step_in = gpfs_pkg::STEP_ENTER;
            digital_in = !analog_mode;
         end
         tx = gpfs_pkg::command_byte(step_in, 8'd0, digital_in, lock_controller);
      end
   end

   always_comb begin
      result.tx_byte = tx;
      result.select_active = sel;
      result.frame_done = fdone;
      result.sequence_done = sdone;
      result.button_byte_a = pad_in[0];
      result.button_byte_b = pad_in[1];
      result.right_x = pad_in[2];
      result.right_y = pad_in[3];
      result.left_x = pad_in[4];
      result.left_y = pad_in[5];
      result.digital_mode = digital_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= gpfs_pkg::STEP_POLL;
         idx_ff <= '0;
         digital_ff <= 1'b0;
         for (int k = 0; k < gpfs_pkg::STORED_BYTES; k++) begin
            pad_ff[k] <= 8'd0;
         end
      end else if (item_take) begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         idx_ff <= idx_in;
         digital_ff <= digital_in;
         pad_ff <= pad_in;
      end
   end

endmodule

/* sv/gamepad_poll_frame_sequencer_top.sv */
`timescale 1ns / 1ps
// Path: an accepted request is registered in the request queue, and its result is registered
// in the result queue before it shows on the result ports. Throughput: one request and one
// result per cycle unless a queue is full; a two-entry queue sits before the sequencer and
// another after it, so either side may stall without stopping the other at once.
// Reset: synchronous and active high; it empties both queues, idles the sequencer, clears the
// stored pad bytes and digital flag, and sets analog_mode and lock_controller to one.
module gamepad_poll_frame_sequencer_top #(
   parameter int unsigned FRAME_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_select_active,
   output logic        rsp_frame_done,
   output logic        rsp_sequence_done,
   output logic [7:0]  rsp_button_byte_a,
   output logic [7:0]  rsp_button_byte_b,
   output logic [7:0]  rsp_right_x,
   output logic [7:0]  rsp_right_y,
   output logic [7:0]  rsp_left_x,
   output logic [7:0]  rsp_left_y,
   output logic        rsp_digital_mode,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                 analog_ff;
   logic                 lock_ff;
   logic                 item_valid;
   logic                 item_take;
   gpfs_pkg::item_type   item;
   logic                 result_full;
   logic                 result_push;
   gpfs_pkg::result_type result;
   gpfs_pkg::result_type head;
   logic [$bits(gpfs_pkg::result_type)-1:0] result_dout;

   assign pready = 1'b1;
   assign prdata = {31'd0, paddr[2] ? lock_ff : analog_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         analog_ff <= 1'b1;
         lock_ff <= 1'b1;
      end else if (psel && penable && pwrite) begin
         if (paddr[2]) lock_ff <= pwdata[0];
         else analog_ff <= pwdata[0];
      end
   end

   gpfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .operation (req_operation),
      .rx_byte   (req_rx_byte),
      .item_valid(item_valid),
      .item      (item),
      .item_take (item_take)
   );

   gpfs_back #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .item_take      (item_take),
      .analog_mode    (analog_ff),
      .lock_controller(lock_ff),
      .result_full    (result_full),
      .result_push    (result_push),
      .result         (result)
   );

   gpfs_fifo #(
      .WIDTH($bits(gpfs_pkg::result_type))
   ) u_result_queue (
      .clock(clock),
      .reset(reset),
      .push (result_push),
      .din  (result),
      .full (result_full),
      .pop  (pop),
      .dout (result_dout),
      .empty(empty)
   );

   assign head = gpfs_pkg::result_type'(result_dout);
   assign rsp_tx_byte = head.tx_byte;
   assign rsp_select_active = head.select_active;
   assign rsp_frame_done = head.frame_done;
   assign rsp_sequence_done = head.sequence_done;
   assign rsp_button_byte_a = head.button_byte_a;
   assign rsp_button_byte_b = head.button_byte_b;
   assign rsp_right_x = head.right_x;
   assign rsp_right_y = head.right_y;
   assign rsp_left_x = head.left_x;
   assign rsp_left_y = head.left_y;
   assign rsp_digital_mode = head.digital_mode;

endmodule

/* sv/gpfs_checker.sv */
`timescale 1ns / 1ps

module gpfs_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_select_active,
   input logic       rsp_frame_done,
   input logic       rsp_sequence_done
);

   a_reset_clears_queues: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("A queue held a transaction after reset.");

   a_sequence_ends_frame: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_sequence_done |-> rsp_frame_done && !rsp_select_active)
      else $error("Sequence ended without ending its frame.");

   a_frame_end_byte: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_frame_done |->
         (rsp_sequence_done && rsp_tx_byte == gpfs_pkg::CMD_ZERO) ||
         (!rsp_sequence_done && rsp_tx_byte == gpfs_pkg::CMD_START))
      else $error("Wrong command byte at the end of a frame.");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_select_active && !rsp_frame_done |-> rsp_tx_byte == gpfs_pkg::CMD_ZERO)
      else $error("Command byte sent while no frame is in progress.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_tx_byte))
      else $error("A waiting result transaction changed before it was taken.");

endmodule

bind gamepad_poll_frame_sequencer_top gpfs_checker u_checker (.*);

/* test/gamepad_poll_frame_sequencer_checker.sv */
`timescale 1ns / 1ps

module gamepad_poll_frame_sequencer_checker #(
   parameter int unsigned FRAME_BYTES = 10,
   parameter logic [2:0]  ANALOG_ADDR = 3'd0,
   parameter logic [2:0]  LOCK_ADDR = 3'd4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic        empty,
   input  logic        pop,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_select_active,
   input  logic        rsp_frame_done,
   input  logic        rsp_sequence_done,
   input  logic [7:0]  rsp_button_byte_a,
   input  logic [7:0]  rsp_button_byte_b,
   input  logic [7:0]  rsp_right_x,
   input  logic [7:0]  rsp_right_y,
   input  logic [7:0]  rsp_left_x,
   input  logic [7:0]  rsp_left_y,
   input  logic        rsp_digital_mode,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          results_waiting
);

   logic                 engaged;
   logic [1:0]           stage;
   int unsigned          slot;
   logic [7:0]           pad_mem [FRAME_BYTES];
   logic                 digital_latch;
   logic                 cfg_analog;
   logic                 cfg_lock;
   gpfs_pkg::result_type awaited_status [$];

   function logic [7:0] frame_cmd(input logic [1:0] stage_now, input int unsigned pos);
      logic [7:0] cmd;
      cmd = gpfs_pkg::CMD_ZERO;
      case (stage_now)
         gpfs_pkg::STEP_POLL: begin
            if (pos == 0) cmd = gpfs_pkg::CMD_START;
            else if (pos == 1) cmd = gpfs_pkg::CMD_READ_DATA;
         end
         gpfs_pkg::STEP_ENTER: begin
            if (pos == 0 || pos == 3) cmd = gpfs_pkg::CMD_START;
            else if (pos == 1) cmd = gpfs_pkg::CMD_CONFIG;
         end
         gpfs_pkg::STEP_MODE: begin
            if (pos == 0) cmd = gpfs_pkg::CMD_START;
            else if (pos == 1) cmd = gpfs_pkg::CMD_MODE;
            else if (pos == 3) cmd = digital_latch ? gpfs_pkg::CMD_ZERO : gpfs_pkg::CMD_START;
            else if (pos == 4) cmd = cfg_lock ? gpfs_pkg::CMD_LOCK : gpfs_pkg::CMD_UNLOCK;
         end
         default: begin
            if (pos == 0) cmd = gpfs_pkg::CMD_START;
            else if (pos == 1) cmd = gpfs_pkg::CMD_CONFIG;
            else if (pos >= 4 && pos <= 8) cmd = gpfs_pkg::CMD_FILL;
         end
      endcase
      return cmd;
   endfunction

   task automatic advance_sequencer(input logic [1:0] op, input logic [7:0] rx,
                                    output gpfs_pkg::result_type status);
      int unsigned next_slot;
      status = '0;
      if (engaged) begin
         status.select_active = 1'b1;
         if (op == gpfs_pkg::OP_RESPONSE) begin
            if (stage == gpfs_pkg::STEP_POLL && (slot == 3 || slot == 4))
               pad_mem[slot] = rx ^ pad_mem[slot];
            else pad_mem[slot] = rx;
            next_slot = slot + 1;
            if (next_slot >= FRAME_BYTES) begin
               status.frame_done = 1'b1;
               status.select_active = 1'b0;
               slot = 0;
               if (stage == gpfs_pkg::STEP_POLL || stage == gpfs_pkg::STEP_EXIT) begin
                  status.sequence_done = 1'b1;
                  engaged = 1'b0;
                  stage = gpfs_pkg::STEP_POLL;
                  status.tx_byte = gpfs_pkg::CMD_ZERO;
               end else begin
                  stage = stage + 2'd1;
                  status.tx_byte = frame_cmd(stage, 0);
               end
            end else begin
               slot = next_slot;
               status.tx_byte = frame_cmd(stage, slot);
            end
         end else begin
            status.tx_byte = frame_cmd(stage, slot);
         end
      end else if (op == gpfs_pkg::OP_POLL || op == gpfs_pkg::OP_CONFIGURE) begin
         engaged = 1'b1;
         slot = 0;
         if (op == gpfs_pkg::OP_POLL) begin
            stage = gpfs_pkg::STEP_POLL;
         end else begin
            stage = gpfs_pkg::STEP_ENTER;
            digital_latch = !cfg_analog;
         end
         status.select_active = 1'b1;
         status.tx_byte = frame_cmd(stage, 0);
      end
      status.button_byte_a = pad_mem[3];
      status.button_byte_b = pad_mem[4];
      status.right_x = pad_mem[5];
      status.right_y = pad_mem[6];
      status.left_x = pad_mem[7];
      status.left_y = pad_mem[8];
      status.digital_mode = digital_latch;
   endtask

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch on %s: expected 0x%02h, got 0x%02h", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      gpfs_pkg::result_type want;
      if (reset) begin
         engaged = 1'b0;
         stage = gpfs_pkg::STEP_POLL;
         slot = 0;
         foreach (pad_mem[i]) pad_mem[i] = '0;
         digital_latch = 1'b0;
         cfg_analog = 1'b1;
         cfg_lock = 1'b1;
         awaited_status.delete();
         mismatches = 0;
      end else begin
         if (pop && !empty) begin
            if (awaited_status.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Result transaction with nothing expected: tx_byte 0x%02h", rsp_tx_byte);
            end else begin
               want = awaited_status.pop_front();
               check_field("tx_byte", want.tx_byte, rsp_tx_byte);
               check_field("select_active", want.select_active, rsp_select_active);
               check_field("frame_done", want.frame_done, rsp_frame_done);
               check_field("sequence_done", want.sequence_done, rsp_sequence_done);
               check_field("button_byte_a", want.button_byte_a, rsp_button_byte_a);
               check_field("button_byte_b", want.button_byte_b, rsp_button_byte_b);
               check_field("right_x", want.right_x, rsp_right_x);
               check_field("right_y", want.right_y, rsp_right_y);
               check_field("left_x", want.left_x, rsp_left_x);
               check_field("left_y", want.left_y, rsp_left_y);
               check_field("digital_mode", want.digital_mode, rsp_digital_mode);
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr == ANALOG_ADDR) cfg_analog = pwdata[0];
            else if (paddr == LOCK_ADDR) cfg_lock = pwdata[0];
         end
         if (push && !full) begin
            advance_sequencer(req_operation, req_rx_byte, want);
            awaited_status.push_back(want);
         end
      end
      results_waiting = awaited_status.size();
   end

endmodule

/* test/gamepad_poll_frame_sequencer_top_tb.sv */
`timescale 1ns / 1ps

module gamepad_poll_frame_sequencer_top_tb;

   localparam int unsigned FRAME_BYTES = 10;
   localparam logic [2:0]  ANALOG_ADDR = 3'd0;
   localparam logic [2:0]  LOCK_ADDR = 3'd4;
   localparam logic [1:0]  OP_NOP = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned HOLD_CYCLES = 150;
   localparam int unsigned PHASE_REQUESTS = 500;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_operation;
   logic [7:0]  req_rx_byte;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_select_active;
   logic        rsp_frame_done;
   logic        rsp_sequence_done;
   logic [7:0]  rsp_button_byte_a;
   logic [7:0]  rsp_button_byte_b;
   logic [7:0]  rsp_right_x;
   logic [7:0]  rsp_right_y;
   logic [7:0]  rsp_left_x;
   logic [7:0]  rsp_left_y;
   logic        rsp_digital_mode;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int          mismatches;
   int          results_waiting;
   int unsigned cycle_count;
   int unsigned requests_sent;
   int unsigned polls_run;
   int unsigned configures_run;
   logic        no_idle;
   logic        hold_ask;
   logic        hold_taken = 1'b0;
   int unsigned hold_left = 0;

   gamepad_poll_frame_sequencer_top #(.FRAME_BYTES(FRAME_BYTES)) uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_operation(req_operation), .req_rx_byte(req_rx_byte),
      .empty(empty), .pop(pop), .rsp_tx_byte(rsp_tx_byte),
      .rsp_select_active(rsp_select_active), .rsp_frame_done(rsp_frame_done),
      .rsp_sequence_done(rsp_sequence_done), .rsp_button_byte_a(rsp_button_byte_a),
      .rsp_button_byte_b(rsp_button_byte_b), .rsp_right_x(rsp_right_x),
      .rsp_right_y(rsp_right_y), .rsp_left_x(rsp_left_x), .rsp_left_y(rsp_left_y),
      .rsp_digital_mode(rsp_digital_mode),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   gamepad_poll_frame_sequencer_checker #(
      .FRAME_BYTES(FRAME_BYTES), .ANALOG_ADDR(ANALOG_ADDR), .LOCK_ADDR(LOCK_ADDR)
   ) watch (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_operation(req_operation), .req_rx_byte(req_rx_byte),
      .empty(empty), .pop(pop), .rsp_tx_byte(rsp_tx_byte),
      .rsp_select_active(rsp_select_active), .rsp_frame_done(rsp_frame_done),
      .rsp_sequence_done(rsp_sequence_done), .rsp_button_byte_a(rsp_button_byte_a),
      .rsp_button_byte_b(rsp_button_byte_b), .rsp_right_x(rsp_right_x),
      .rsp_right_y(rsp_right_y), .rsp_left_x(rsp_left_x), .rsp_left_y(rsp_left_y),
      .rsp_digital_mode(rsp_digital_mode),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .pready(pready), .mismatches(mismatches), .results_waiting(results_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[gamepad_poll_frame_sequencer_top] ERROR");
         $finish;
      end
   end

   // The result side is held off once for a long stretch, so that the queues fill and each
   // request transaction is stalled until results drain again.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left != 0) begin
         pop <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_ask && !hold_taken) begin
         pop <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (no_idle) begin
         pop <= 1'b1;
      end else begin
         pop <= ($urandom_range(99) >= 37);
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic offer_request(input logic [1:0] op, input logic [7:0] rx);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 37) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_operation <= op;
      req_rx_byte <= rx;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic settle_block();
      @(negedge clock);
      push <= 1'b0;
      while (results_waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic value);
      logic [31:0] word;
      word = $urandom;
      word[0] = value;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= word;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic run_sequence(input logic [1:0] start_op);
      int unsigned frames;
      int unsigned n;
      logic [1:0]  stray_op;
      frames = (start_op == gpfs_pkg::OP_CONFIGURE) ? 3 : 1;
      offer_request(start_op, pick_byte());
      requests_sent++;
      for (n = 0; n < frames * FRAME_BYTES; n++) begin
         if ($urandom_range(99) < 8) begin
            case ($urandom_range(2))
               0: stray_op = gpfs_pkg::OP_POLL;
               1: stray_op = gpfs_pkg::OP_CONFIGURE;
               default: stray_op = OP_NOP;
            endcase
            offer_request(stray_op, pick_byte());
         end
         offer_request(gpfs_pkg::OP_RESPONSE, pick_byte());
         requests_sent++;
      end
   endtask

   task automatic run_phase(input logic analog, input logic lock, input logic hold_results);
      int unsigned target;
      int unsigned pick;
      settle_block();
      csr_write(ANALOG_ADDR, analog);
      csr_write(LOCK_ADDR, lock);
      if (hold_results) hold_ask <= 1'b1;
      target = requests_sent + PHASE_REQUESTS;
      while (requests_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            repeat ($urandom_range(4, 1)) offer_request(gpfs_pkg::OP_RESPONSE, pick_byte());
         end else if (pick < 10) begin
            offer_request(OP_NOP, pick_byte());
         end else if (pick < 70) begin
            run_sequence(gpfs_pkg::OP_POLL);
            polls_run++;
         end else begin
            run_sequence(gpfs_pkg::OP_CONFIGURE);
            configures_run++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_operation = OP_NOP;
      req_rx_byte = 8'h00;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      no_idle = 1'b0;
      hold_ask = 1'b0;
      requests_sent = 0;
      polls_run = 0;
      configures_run = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      offer_request(gpfs_pkg::OP_RESPONSE, 8'hFF);
      offer_request(OP_NOP, 8'h00);
      offer_request(gpfs_pkg::OP_POLL, 8'h00);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'hFF);
      offer_request(gpfs_pkg::OP_CONFIGURE, 8'hFF);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'h00);
      offer_request(gpfs_pkg::OP_POLL, 8'h5A);
      offer_request(OP_NOP, 8'hFF);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'hFF);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'hFF);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'h5A);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'h00);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'hFF);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'h80);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'h01);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'h7F);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'hAA);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'h00);
      offer_request(gpfs_pkg::OP_RESPONSE, 8'hFF);
      requests_sent += 11;
      polls_run++;

      run_phase(1'b0, 1'b0, 1'b1);
      no_idle <= 1'b1;
      run_phase(1'b1, 1'b0, 1'b0);
      no_idle <= 1'b0;
      run_phase(1'b0, 1'b1, 1'b0);
      run_phase(1'b1, 1'b1, 1'b0);
      settle_block();

      $display("Sent %0d counted requests in %0d poll and %0d configure sequences,",
               requests_sent, polls_run, configures_run);
      $display("with stray requests, four register settings and stalls on both sides.");
      if (mismatches == 0) begin
         $display("[gamepad_poll_frame_sequencer_top] OK");
      end else begin
         $display("[gamepad_poll_frame_sequencer_top] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
sv/gpfs_pkg.sv
sv/gpfs_fifo.sv
sv/gpfs_front.sv
sv/gpfs_back.sv
sv/gamepad_poll_frame_sequencer_top.sv
sv/gpfs_checker.sv
test/gamepad_poll_frame_sequencer_checker.sv
test/gamepad_poll_frame_sequencer_top_tb.sv
